// ----- rtl/core/uart_bit_level_transceiver_defines.svh -----
// Assertion macros shared by the UART transceiver RTL.
`ifndef UART_BIT_LEVEL_TRANSCEIVER_DEFINES_SVH
`define UART_BIT_LEVEL_TRANSCEIVER_DEFINES_SVH

// Whenever the condition holds, the consequence holds in the same cycle.
`define UBT_ASSERT_SAME(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("UART transceiver check failed");

// Whenever the condition holds, the consequence holds in the next cycle.
`define UBT_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("UART transceiver check failed");

`endif

// ----- rtl/core/ubt_pkg.sv -----
// Types, codes and frame helper functions for the UART transceiver.
package ubt_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2
    } ubt_req_type_e;

    localparam logic [2:0] ADDR_STATUS = 3'd0;
    localparam logic [2:0] ADDR_TX     = 3'd1;
    localparam logic [2:0] ADDR_RX     = 3'd2;

    localparam logic [2:0] CFG_WORD_LENGTH   = 3'd0;
    localparam logic [2:0] CFG_TWO_STOP_BITS = 3'd1;
    localparam logic [2:0] CFG_PARITY_ON     = 3'd2;
    localparam logic [2:0] CFG_PARITY_ODD    = 3'd3;
    localparam logic [2:0] CFG_RX_IRQ_ENABLE = 3'd4;
    localparam logic [2:0] CFG_TX_IRQ_ENABLE = 3'd5;
    localparam logic [2:0] CFG_AUTO_ECHO     = 3'd6;

    // Bit positions inside the status flags.
    localparam int unsigned ST_TX_EMPTY = 0;
    localparam int unsigned ST_RX_FULL  = 1;
    localparam int unsigned ST_OVERRUN  = 2;
    localparam int unsigned ST_FRAME    = 3;
    localparam int unsigned ST_PARITY   = 4;
    localparam int unsigned ST_IRQ      = 5;

    // Longest frame: start, eight data bits, parity, two stop bits.
    localparam logic [3:0] MAX_FRAME_LEN = 4'd12;

    typedef struct packed {
        logic [3:0] word_length;
        logic       two_stop_bits;
        logic       parity_on;
        logic       parity_odd;
        logic       rx_irq_enable;
        logic       tx_irq_enable;
        logic       auto_echo;
    } ubt_cfg_t;

    typedef struct packed {
        ubt_req_type_e req_type;
        logic [2:0]    address;
        logic [7:0]    write_data;
        logic          rx_level;
    } ubt_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_level;
        logic       irq;
    } ubt_rsp_t;

    typedef struct packed {
        logic [3:0] tx_bit_index;
        logic [3:0] rx_bit_index;
        logic [7:0] tx_shift_byte;
        logic [7:0] rx_byte;
        logic [5:0] status_flags;
        logic       tx_line_out;
    } ubt_state_t;

    localparam ubt_state_t UBT_STATE_RESET = '{
        tx_bit_index:  4'd0,
        rx_bit_index:  4'd0,
        tx_shift_byte: 8'd0,
        rx_byte:       8'd0,
        status_flags:  6'b000001,
        tx_line_out:   1'b0
    };

    localparam ubt_cfg_t UBT_CFG_RESET = '{
        word_length:   4'd8,
        two_stop_bits: 1'b0,
        parity_on:     1'b0,
        parity_odd:    1'b0,
        rx_irq_enable: 1'b0,
        tx_irq_enable: 1'b0,
        auto_echo:     1'b0
    };

    // Zero acts as one data bit, anything above eight as eight.
    function automatic logic [3:0] eff_len(input logic [3:0] wl);
        logic [3:0] len;
        if (wl == 4'd0) begin
            len = 4'd1;
        end else if (wl > 4'd8) begin
            len = 4'd8;
        end else begin
            len = wl;
        end
        return len;
    endfunction

    function automatic logic [3:0] frame_len(input ubt_cfg_t cfg);
        logic [3:0] stop_bits;
        stop_bits = cfg.two_stop_bits ? 4'd2 : 4'd1;
        return 4'd1 + eff_len(cfg.word_length) + {3'd0, cfg.parity_on} + stop_bits;
    endfunction

    function automatic logic parity_of(input ubt_cfg_t cfg, input logic [7:0] data);
        logic [7:0] mask;
        mask = 8'hFF >> (4'd8 - eff_len(cfg.word_length));
        return (^(data & mask)) ^ cfg.parity_odd;
    endfunction

    function automatic ubt_state_t tx_advance(input ubt_cfg_t cfg, input ubt_state_t st);
        ubt_state_t s;
        logic [3:0] n;
        s = st;
        n = st.tx_bit_index + 4'd1;
        if (n > frame_len(cfg)) begin
            n = 4'd0;
            s.status_flags[ST_TX_EMPTY] = 1'b1;
            if (cfg.tx_irq_enable) begin
                s.status_flags[ST_IRQ] = 1'b1;
            end
        end else if (n == 4'd1) begin
            s.status_flags[ST_TX_EMPTY] = 1'b0;
        end
        s.tx_bit_index = n;
        return s;
    endfunction

    // A load while a frame is on the line flags overrun but still replaces the byte.
    function automatic ubt_state_t tx_load(input ubt_cfg_t cfg, input ubt_state_t st,
                                           input logic [7:0] data);
        ubt_state_t s;
        s = st;
        if (!s.status_flags[ST_TX_EMPTY]) begin
            s.status_flags[ST_OVERRUN] = 1'b1;
        end else begin
            s.status_flags[ST_OVERRUN] = 1'b0;
            s = tx_advance(cfg, s);
        end
        s.tx_shift_byte = data;
        return s;
    endfunction

    function automatic ubt_state_t tx_tick(input ubt_cfg_t cfg, input ubt_state_t st);
        ubt_state_t s;
        logic [3:0] k;
        logic [3:0] j;
        logic [3:0] len;
        s = st;
        k = st.tx_bit_index - 4'd1;
        j = k - 4'd1;
        len = eff_len(cfg.word_length);
        if (st.tx_bit_index != 4'd0) begin
            if (k == 4'd0) begin
                s.tx_line_out = 1'b1;
            end else if (j < len) begin
                s.tx_line_out = st.tx_shift_byte[j[2:0]];
            end else if (cfg.parity_on && (j == len)) begin
                s.tx_line_out = parity_of(cfg, st.tx_shift_byte);
            end else begin
                s.tx_line_out = 1'b0;
            end
            s = tx_advance(cfg, s);
        end
        return s;
    endfunction

    function automatic ubt_state_t rx_tick(input ubt_cfg_t cfg, input ubt_state_t st,
                                           input logic level);
        ubt_state_t s;
        logic [3:0] k;
        logic [3:0] j;
        logic [3:0] n;
        logic [3:0] len;
        s = st;
        len = eff_len(cfg.word_length);
        if ((st.rx_bit_index != 4'd0) || level) begin
            // A high level on an idle line is the start bit.
            if (st.rx_bit_index == 4'd0) begin
                s.status_flags[ST_RX_FULL] = 1'b0;
                s.rx_bit_index = 4'd1;
            end
            k = s.rx_bit_index - 4'd1;
            j = k - 4'd1;
            if (k == 4'd0) begin
                s.rx_byte = 8'd0;
            end else if (j < len) begin
                s.rx_byte[j[2:0]] = s.rx_byte[j[2:0]] | level;
            end else if (cfg.parity_on && (j == len)) begin
                if (level != parity_of(cfg, s.rx_byte)) begin
                    s.status_flags[ST_PARITY] = 1'b1;
                end
            end else if (level) begin
                s.status_flags[ST_FRAME] = 1'b1;
            end
            n = s.rx_bit_index + 4'd1;
            if (n > frame_len(cfg)) begin
                s.status_flags[ST_RX_FULL] = 1'b1;
                if (cfg.rx_irq_enable) begin
                    s.status_flags[ST_IRQ] = 1'b1;
                end
                s.rx_bit_index = 4'd0;
                if (cfg.auto_echo) begin
                    s = tx_load(cfg, s, s.rx_byte);
                end
            end else begin
                if (n == 4'd1) begin
                    s.status_flags[ST_RX_FULL] = 1'b0;
                end
                s.rx_bit_index = n;
            end
        end
        return s;
    endfunction

endpackage

// ----- rtl/core/uart_bit_level_transceiver.sv -----
// Each accepted request passes the input register, then the result register.
// One request per cycle unless m_tready stalls; the two registers flow together.
// Every request (bit-time tick, register write or read) gives exactly one result.
// Reset (rst_n low, asynchronous) clears all line, index and flag state,
// sets tx empty, and returns the configuration registers to their defaults.
`include "uart_bit_level_transceiver_defines.svh"

module uart_bit_level_transceiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] address, [10:3] write_data, [11] rx_level
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] read_data, [8] tx_level, [9] irq
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    import ubt_pkg::*;

    ubt_cfg_t cfg_reg;
    ubt_req_t in_req_reg;
    logic     in_valid_reg;
    ubt_rsp_t out_rsp_reg;
    logic     out_valid_reg;
    ubt_rsp_t core_rsp;
    logic     advance;
    logic     step_en;
    logic     in_accept;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign step_en   = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= UBT_CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WORD_LENGTH:   cfg_reg.word_length   <= cfg_data;
                CFG_TWO_STOP_BITS: cfg_reg.two_stop_bits <= cfg_data[0];
                CFG_PARITY_ON:     cfg_reg.parity_on     <= cfg_data[0];
                CFG_PARITY_ODD:    cfg_reg.parity_odd    <= cfg_data[0];
                CFG_RX_IRQ_ENABLE: cfg_reg.rx_irq_enable <= cfg_data[0];
                CFG_TX_IRQ_ENABLE: cfg_reg.tx_irq_enable <= cfg_data[0];
                CFG_AUTO_ECHO:     cfg_reg.auto_echo     <= cfg_data[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            in_req_reg.req_type   <= ubt_req_type_e'(s_tuser);
            in_req_reg.address    <= s_tdata[2:0];
            in_req_reg.write_data <= s_tdata[10:3];
            in_req_reg.rx_level   <= s_tdata[11];
        end
        if (step_en) begin
            out_rsp_reg <= core_rsp;
        end
    end

    ubt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .step_en (step_en),
        .req     (in_req_reg),
        .rsp     (core_rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_rsp_reg.irq, out_rsp_reg.tx_level, out_rsp_reg.read_data};

    `UBT_ASSERT_SAME(a_ready_when_out_free, !out_valid_reg, s_tready)
    `UBT_ASSERT_NEXT(a_drain_empties_out, out_valid_reg && m_tready && !in_valid_reg, !out_valid_reg)
    `UBT_ASSERT_SAME(a_out_from_in_stage, $rose(out_valid_reg), $past(in_valid_reg))

endmodule

// ----- rtl/core/ubt_core.sv -----
// Transceiver state registers and the single-pass update for one request.
`include "uart_bit_level_transceiver_defines.svh"

module ubt_core (
    input  logic              clk,
    input  logic              rst_n,
    input  ubt_pkg::ubt_cfg_t cfg,
    input  logic              step_en,
    input  ubt_pkg::ubt_req_t req,
    output ubt_pkg::ubt_rsp_t rsp
);
    import ubt_pkg::*;

    ubt_state_t state_reg;
    ubt_state_t state_next;
    logic [7:0] read_data;

    always_comb
    begin
        state_next = state_reg;
        read_data  = 8'd0;
        unique case (req.req_type)
            REQ_TICK:
            begin
                state_next = rx_tick(cfg, tx_tick(cfg, state_reg), req.rx_level);
            end
            REQ_WRITE:
            begin
                unique case (req.address)
                    ADDR_STATUS: state_next = UBT_STATE_RESET;
                    ADDR_TX:     state_next = tx_load(cfg, state_reg, req.write_data);
                    ADDR_RX:     state_next.rx_byte = req.write_data;
                    default:     state_next = state_reg;
                endcase
            end
            REQ_READ:
            begin
                unique case (req.address)
                    ADDR_STATUS:
                    begin
                        // Reading status acknowledges the interrupt.
                        read_data = {2'b00, state_reg.status_flags};
                        state_next.status_flags[ST_IRQ] = 1'b0;
                    end
                    ADDR_TX:
                    begin
                        read_data = state_reg.tx_shift_byte;
                    end
                    ADDR_RX:
                    begin
                        read_data = state_reg.rx_byte;
                        state_next.status_flags[ST_RX_FULL] = 1'b0;
                        state_next.status_flags[ST_OVERRUN] = 1'b0;
                        state_next.status_flags[ST_FRAME]   = 1'b0;
                        state_next.status_flags[ST_PARITY]  = 1'b0;
                    end
                    default:
                    begin
                        read_data = 8'd0;
                    end
                endcase
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= UBT_STATE_RESET;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    assign rsp.read_data = read_data;
    assign rsp.tx_level  = state_next.tx_line_out;
    assign rsp.irq       = state_next.status_flags[ST_IRQ];

    `UBT_ASSERT_SAME(a_tx_empty_idle, 1'b1, state_reg.status_flags[ST_TX_EMPTY] == (state_reg.tx_bit_index == 4'd0))
    `UBT_ASSERT_SAME(a_rx_index_range, 1'b1, state_reg.rx_bit_index <= MAX_FRAME_LEN)
    `UBT_ASSERT_NEXT(a_hold_when_idle, !step_en, $stable(state_reg))

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the bit-level UART transceiver and its register map.
module tb;
    import ubt_pkg::*;

    localparam logic [1:0] REQ_NOP     = 2'd3;  // undefined request kind, must do nothing
    localparam logic [2:0] ADDR_UNUSED = 3'd7;
    localparam logic [2:0] CFG_UNUSED  = 3'd7;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 172;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] addr;
        logic [7:0] wdata;
        logic       level;
    } bus_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [2:0] address, [10:3] write_data, [11] rx_level
    logic [1:0]  s_tuser = '0;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [7:0] read_data, [8] tx_level, [9] irq
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;

    // Configuration as last written to the block.
    logic [3:0] wlen_cfg = 4'd8;
    logic       two_stop_cfg = 1'b0;
    logic       par_en_cfg = 1'b0;
    logic       par_odd_cfg = 1'b0;
    logic       rx_irq_cfg = 1'b0;
    logic       tx_irq_cfg = 1'b0;
    logic       echo_cfg = 1'b0;

    // Line, index and flag state of both directions.
    logic [3:0] tx_pos = 4'd0;
    logic [3:0] rx_pos = 4'd0;
    logic [7:0] tx_hold = 8'd0;
    logic [7:0] rx_shift = 8'd0;
    logic [5:0] flags = 6'b000001;
    logic       tx_line = 1'b0;

    bus_req_t requests_todo[$];
    ubt_rsp_t replies_due[$];
    bus_req_t on_bus;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    int queued = 0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;

    uart_bit_level_transceiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int data_bits();
        if (wlen_cfg == 4'd0) return 1;
        if (wlen_cfg > 4'd8) return 8;
        return int'(wlen_cfg);
    endfunction

    function automatic int frame_bits();
        return 1 + data_bits() + (par_en_cfg ? 1 : 0) + (two_stop_cfg ? 2 : 1);
    endfunction

    function automatic logic parity_bit(input logic [7:0] b);
        logic p;
        int i;
        p = par_odd_cfg;
        for (i = 0; i < data_bits(); i++) p = p ^ b[i];
        return p;
    endfunction

    function automatic void tx_step_index();
        logic [3:0] n;
        n = tx_pos + 4'd1;
        if (int'(n) > frame_bits())
        begin
            n = 4'd0;
            flags[ST_TX_EMPTY] = 1'b1;
            if (tx_irq_cfg) flags[ST_IRQ] = 1'b1;
        end
        else if (n == 4'd1)
        begin
            flags[ST_TX_EMPTY] = 1'b0;
        end
        tx_pos = n;
    endfunction

    // A byte loaded while a frame is on the line flags overrun but still replaces it.
    function automatic void tx_take(input logic [7:0] b);
        if (!flags[ST_TX_EMPTY])
        begin
            flags[ST_OVERRUN] = 1'b1;
        end
        else
        begin
            flags[ST_OVERRUN] = 1'b0;
            tx_step_index();
        end
        tx_hold = b;
    endfunction

    function automatic void rx_step_index();
        logic [3:0] n;
        n = rx_pos + 4'd1;
        if (int'(n) > frame_bits())
        begin
            flags[ST_RX_FULL] = 1'b1;
            if (rx_irq_cfg) flags[ST_IRQ] = 1'b1;
            rx_pos = 4'd0;
            if (echo_cfg) tx_take(rx_shift);
        end
        else
        begin
            if (n == 4'd1) flags[ST_RX_FULL] = 1'b0;
            rx_pos = n;
        end
    endfunction

    function automatic void tx_bit_time();
        int k;
        int j;
        if (tx_pos == 4'd0) return;
        k = int'(tx_pos) - 1;
        j = k - 1;
        if (k == 0)
            tx_line = 1'b1;
        else if (j < data_bits())
            tx_line = tx_hold[j];
        else if (par_en_cfg && j == data_bits())
            tx_line = parity_bit(tx_hold);
        else
            tx_line = 1'b0;
        tx_step_index();
    endfunction

    function automatic void rx_bit_time(input logic level);
        int k;
        int j;
        if (rx_pos == 4'd0)
        begin
            // A high level on an idle line is taken as the start bit.
            if (!level) return;
            rx_step_index();
        end
        k = int'(rx_pos) - 1;
        j = k - 1;
        if (k == 0)
            rx_shift = 8'd0;
        else if (j < data_bits())
            rx_shift[j] = rx_shift[j] | level;
        else if (par_en_cfg && j == data_bits())
        begin
            if (level != parity_bit(rx_shift)) flags[ST_PARITY] = 1'b1;
        end
        else if (level)
            flags[ST_FRAME] = 1'b1;
        rx_step_index();
    endfunction

    function automatic ubt_rsp_t uart_reply(input bus_req_t r);
        ubt_rsp_t o;
        o.read_data = 8'd0;
        if (r.kind == REQ_TICK)
        begin
            tx_bit_time();
            rx_bit_time(r.level);
        end
        else if (r.kind == REQ_WRITE)
        begin
            if (r.addr == ADDR_STATUS)
            begin
                // Soft reset: all line state goes back, configuration stays.
                tx_pos = 4'd0;
                rx_pos = 4'd0;
                tx_hold = 8'd0;
                rx_shift = 8'd0;
                flags = 6'b000001;
                tx_line = 1'b0;
            end
            else if (r.addr == ADDR_TX)
                tx_take(r.wdata);
            else if (r.addr == ADDR_RX)
                rx_shift = r.wdata;
        end
        else if (r.kind == REQ_READ)
        begin
            if (r.addr == ADDR_STATUS)
            begin
                o.read_data = {2'b00, flags};
                flags[ST_IRQ] = 1'b0;
            end
            else if (r.addr == ADDR_TX)
                o.read_data = tx_hold;
            else if (r.addr == ADDR_RX)
            begin
                flags[ST_RX_FULL] = 1'b0;
                flags[ST_OVERRUN] = 1'b0;
                flags[ST_FRAME] = 1'b0;
                flags[ST_PARITY] = 1'b0;
                o.read_data = rx_shift;
            end
        end
        o.tx_level = tx_line;
        o.irq = flags[ST_IRQ];
        return o;
    endfunction

    function automatic void add_req(input logic [1:0] kind, input logic [2:0] addr,
                                    input logic [7:0] wdata, input logic level);
        bus_req_t r;
        r.kind = kind;
        r.addr = addr;
        r.wdata = wdata;
        r.level = level;
        requests_todo.push_back(r);
        if (kind == REQ_TICK || (kind != REQ_NOP && addr <= ADDR_RX)) queued++;
    endfunction

    function automatic void add_tick(input logic level);
        add_req(REQ_TICK, 3'($urandom), 8'($urandom), level);
    endfunction

    function automatic void add_read(input logic [2:0] addr);
        add_req(REQ_READ, addr, 8'($urandom), 1'($urandom));
    endfunction

    function automatic void add_tx_write(input logic [7:0] b);
        add_req(REQ_WRITE, ADDR_TX, b, 1'($urandom));
    endfunction

    function automatic void add_side_access();
        case ($urandom_range(0, 3))
            0: add_read(ADDR_STATUS);
            1: add_read(ADDR_RX);
            2: add_read(ADDR_TX);
            default: add_tx_write(8'($urandom));
        endcase
    endfunction

    function automatic void add_rx_frame(input logic [7:0] b, input bit bad_par,
                                         input bit bad_stop);
        int i;
        int stops;
        stops = two_stop_cfg ? 2 : 1;
        add_tick(1'b1);
        for (i = 0; i < data_bits(); i++)
        begin
            if ($urandom_range(0, 9) == 0) add_side_access();
            add_tick(b[i]);
        end
        if (par_en_cfg) add_tick(parity_bit(b) ^ bad_par);
        for (i = 0; i < stops; i++) add_tick(bad_stop && i == stops - 1);
    endfunction

    // Mostly well-formed receive frames and transmit loads, with some noise mixed in.
    function automatic void add_traffic(input int budget);
        int i;
        int n;
        queued = 0;
        while (queued < budget)
        begin
            n = $urandom_range(0, 19);
            if (n < 10)
            begin
                if ($urandom_range(0, 9) < 3) add_tx_write(8'($urandom));
                add_rx_frame(8'($urandom), $urandom_range(0, 7) == 0,
                             $urandom_range(0, 7) == 0);
                for (i = $urandom_range(0, 3); i > 0; i--) add_tick(1'b0);
                if ($urandom_range(0, 1)) add_read(ADDR_STATUS);
                if ($urandom_range(0, 9) < 6) add_read(ADDR_RX);
            end
            else if (n < 14)
            begin
                add_tx_write(8'($urandom));
                for (i = 0; i <= frame_bits(); i++)
                    add_tick($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 1)) add_read(ADDR_STATUS);
            end
            else if (n < 16)
            begin
                add_tx_write(8'($urandom));
                for (i = $urandom_range(2, 4); i > 0; i--) add_tick(1'b0);
                add_tx_write(8'($urandom));
                add_read(ADDR_STATUS);
                for (i = 0; i < frame_bits(); i++) add_tick(1'b0);
            end
            else if (n == 16)
            begin
                for (i = 0; i < 3; i++) add_read(3'($urandom));
            end
            else if (n < 19)
            begin
                for (i = $urandom_range(4, 8); i > 0; i--)
                    add_req(2'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
            end
            else
            begin
                add_req(REQ_WRITE, ADDR_RX, 8'($urandom), 1'($urandom));
                add_read(ADDR_RX);
            end
        end
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (requests_todo.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WORD_LENGTH) wlen_cfg = val;
        else if (idx == CFG_TWO_STOP_BITS) two_stop_cfg = val[0];
        else if (idx == CFG_PARITY_ON) par_en_cfg = val[0];
        else if (idx == CFG_PARITY_ODD) par_odd_cfg = val[0];
        else if (idx == CFG_RX_IRQ_ENABLE) rx_irq_cfg = val[0];
        else if (idx == CFG_TX_IRQ_ENABLE) tx_irq_cfg = val[0];
        else if (idx == CFG_AUTO_ECHO) echo_cfg = val[0];
    endtask

    // Single-bit registers get random upper data bits, which the block must ignore.
    task automatic start_phase(input logic [3:0] wlen, input logic two, input logic pen,
                               input logic podd, input logic rxi, input logic txi,
                               input logic echo, input int s_idle, input int r_stall);
        wait_drained();
        write_reg(CFG_WORD_LENGTH, wlen);
        write_reg(CFG_TWO_STOP_BITS, {3'($urandom), two});
        write_reg(CFG_PARITY_ON, {3'($urandom), pen});
        write_reg(CFG_PARITY_ODD, {3'($urandom), podd});
        write_reg(CFG_RX_IRQ_ENABLE, {3'($urandom), rxi});
        write_reg(CFG_TX_IRQ_ENABLE, {3'($urandom), txi});
        write_reg(CFG_AUTO_ECHO, {3'($urandom), echo});
        write_reg(CFG_UNUSED, 4'($urandom));
        @(negedge clk);
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        add_traffic(PHASE_ITEMS);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_read(ADDR_STATUS);
        add_read(ADDR_TX);
        add_req(REQ_WRITE, ADDR_RX, 8'hFF, 1'b1);
        add_read(ADDR_RX);
        add_req(REQ_WRITE, ADDR_UNUSED, 8'h5A, 1'b0);
        add_read(ADDR_UNUSED);
        add_req(REQ_NOP, ADDR_STATUS, 8'hFF, 1'b1);
        add_tx_write(8'h00);
        add_tx_write(8'hFF);  // second load lands on a busy transmitter
        add_tick(1'b1);
        add_tick(1'b0);
        add_tick(1'b1);
        add_tick(1'b1);
        add_read(ADDR_STATUS);
        add_read(ADDR_TX);
        add_req(REQ_WRITE, ADDR_STATUS, 8'hFF, 1'b1);
        add_read(ADDR_STATUS);
        add_tick(1'b0);
        add_read(ADDR_RX);

        start_phase(4'd8, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 0, 0);
        start_phase(4'd1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 64, 0);
        start_phase(4'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 0, 64);
        long_hold_req = 1'b1;
        start_phase(4'd15, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 27, 27);
        start_phase(4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom), 0, 0);
        start_phase(4'd5, 1'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom), 64, 0);
        start_phase(4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom), 0, 64);
        start_phase(4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom), 27, 27);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Driver: an accepted request advances the predicted state at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready) replies_due.push_back(uart_reply(on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (requests_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    on_bus = requests_todo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'd0, on_bus.level, on_bus.wdata, on_bus.addr};
                    s_tuser <= on_bus.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        ubt_rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result transaction with no request waiting: m_tdata %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (m_tdata[7:0] !== want.read_data)
                begin
                    $error("read_data: expected %0h, got %0h", want.read_data, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[8] !== want.tx_level)
                begin
                    $error("tx_level: expected %0b, got %0b", want.tx_level, m_tdata[8]);
                    fail_count++;
                end
                if (m_tdata[9] !== want.irq)
                begin
                    $error("irq: expected %0b, got %0b", want.irq, m_tdata[9]);
                    fail_count++;
                end
            end
        end
        // One long hold-off lets the pipeline fill and back up into the input.
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
